/* design/tile_table_aabb_collision_top_macros.svh */
// assertion helpers, sampled on clk_i and held off during reset
`ifndef TILE_TABLE_AABB_COLLISION_TOP_MACROS_SVH
`define TILE_TABLE_AABB_COLLISION_TOP_MACROS_SVH

`define TTAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define TTAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/ttac_pkg.sv */
package ttac_pkg;

  localparam int MAX_TILES = 256;
  localparam int IDX_W     = $clog2(MAX_TILES);
  localparam int CNT_W     = $clog2(MAX_TILES + 1);
  localparam int LVL_N     = $clog2(MAX_TILES);
  localparam int CMP_W     = 26;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } ttac_op_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_APPLY = 3'b100
  } ttac_state_e;

  typedef struct packed {
    logic signed [15:0] col;
    logic signed [15:0] row;
    logic               solid;
  } ttac_entry_t;

  typedef struct packed {
    logic               append;
    logic               replace;
    logic               shift;
    logic signed [15:0] col;
    logic signed [15:0] row;
    logic               solid;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic        [15:0] bw;
    logic        [15:0] bh;
  } ttac_cmd_t;

endpackage

/* design/tile_table_aabb_collision_top.sv */
// Tile table with box collision. Each item is handled in these steps in order: it is
// accepted and registered for broadcast down the chain of tile cells, then every cell
// compares its stored tile against the broadcast position or box, and then the block
// resolves the first match through a prefix network and applies the set, the remove (the
// matching cell and each cell past it take their neighbor's tile) or the query reduction.
// The result is registered at the end of the apply step. A new item is taken in
// the cycle after the result is loaded, so no item is accepted while another is
// in flight; a stalled result holds the next item before its apply cycle. After
// reset the table is empty.
`include "tile_table_aabb_collision_top_macros.svh"

module tile_table_aabb_collision_top
  import ttac_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] tile_x_i,
  input  logic signed [15:0] tile_y_i,
  input  logic               replace_existing_i,
  input  logic               collidable_i,
  input  logic signed [23:0] box_x_i,
  input  logic signed [23:0] box_y_i,
  input  logic [15:0]        box_w_i,
  input  logic [15:0]        box_h_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               removed_o,
  output logic               collides_o,
  output logic               insert_dropped_o
);

  ttac_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       op_q;
  logic             repl_q, solid_q;
  logic signed [15:0] col_q, row_q;
  logic signed [23:0] bx_q, by_q;
  logic [15:0]      bw_q, bh_q;
  logic             out_valid_q, removed_q, collides_q, dropped_q;
  logic             removed_d, collides_d, dropped_d;

  ttac_cmd_t            cmd;
  ttac_entry_t          ent [MAX_TILES];
  logic [MAX_TILES-1:0] match, hit, incl, first;
  logic                 accept, apply, any, full;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = state_q == S_IDLE;
  assign apply      = state_q == S_APPLY;
  assign any        = |match;
  assign full       = count_q == CNT_W'(MAX_TILES);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      col_q   <= tile_x_i;
      row_q   <= tile_y_i;
      repl_q  <= replace_existing_i;
      solid_q <= collidable_i;
      bx_q    <= box_x_i;
      by_q    <= box_y_i;
      bw_q    <= box_w_i;
      bh_q    <= box_h_i;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.col     = col_q;
    cmd.row     = row_q;
    cmd.solid   = solid_q;
    cmd.bx      = bx_q;
    cmd.by      = by_q;
    cmd.bw      = bw_q;
    cmd.bh      = bh_q;
    count_d     = count_q;
    removed_d   = 1'b0;
    collides_d  = 1'b0;
    dropped_d   = 1'b0;
    if (apply) begin
      case (op_q)
        OP_SET: begin
          if (repl_q && any) begin
            cmd.replace = 1'b1;
          end else if (full) begin
            dropped_d = 1'b1;
          end else begin
            cmd.append = 1'b1;
            count_d    = count_q + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (any) begin
            cmd.shift = 1'b1;
            count_d   = count_q - CNT_W'(1);
            removed_d = 1'b1;
          end
        end
        OP_QUERY: begin
          collides_d = |hit;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!out_valid_q || out_ready_i) state_d = S_APPLY;
      end
      S_APPLY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      removed_q  <= removed_d;
      collides_q <= collides_d;
      dropped_q  <= dropped_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign removed_o        = removed_q;
  assign collides_o       = collides_q;
  assign insert_dropped_o = dropped_q;

  ttac_prefix u_prefix (
    .match_i (match),
    .incl_o  (incl),
    .first_o (first)
  );

  for (genvar i = 0; i < MAX_TILES; i++) begin : g_cell
    ttac_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .count_i (count_q),
      .cmd_i   (cmd),
      .first_i (first[i]),
      .shift_i (incl[i]),
      .nxt_i   (ent[(i + 1 < MAX_TILES) ? i + 1 : i]),
      .ent_o   (ent[i]),
      .match_o (match[i]),
      .hit_o   (hit[i])
    );
  end

  `TTAC_ASSERT(a_count_max, count_q <= CNT_W'(MAX_TILES), "tile count above table size")
  `TTAC_ASSERT(a_first_one, $onehot0(first), "more than one first match")
  `TTAC_ASSERT_IMP(a_accept_eval, accept, ##1 (state_q == S_EVAL), "item not evaluated")
  `TTAC_ASSERT_IMP(a_count_apply, count_q != $past(count_q), $past(apply), "count moved outside apply")
  `TTAC_ASSERT_IMP(a_out_rise, $rose(out_valid_q), $past(apply), "result without apply")

endmodule

/* design/ttac_prefix.sv */
module ttac_prefix
  import ttac_pkg::*;
(
  input  logic [MAX_TILES-1:0] match_i,
  output logic [MAX_TILES-1:0] incl_o,
  output logic [MAX_TILES-1:0] first_o
);

  logic [MAX_TILES-1:0] lvl [LVL_N+1];

  // log-depth prefix or, lowest index first
  always_comb begin
    lvl[0] = match_i;
    for (int l = 0; l < LVL_N; l++) begin
      lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
    end
  end

  assign incl_o  = lvl[LVL_N];
  assign first_o = match_i & ~(lvl[LVL_N] << 1);

endmodule

/* design/ttac_cell.sv */
module ttac_cell
  import ttac_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [CNT_W-1:0] count_i,
  input  ttac_cmd_t        cmd_i,
  input  logic             first_i,
  input  logic             shift_i,
  input  ttac_entry_t      nxt_i,
  output ttac_entry_t      ent_o,
  output logic             match_o,
  output logic             hit_o
);

  ttac_entry_t ent_q;
  logic        match_q, hit_q;
  logic        valid, at_end, match_d, hit_d;
  logic signed [CMP_W-1:0] lo_x, hi_x, lo_y, hi_y, bx0, bx1, by0, by1;

  assign valid  = {1'b0, idx_i} < count_i;
  assign at_end = {1'b0, idx_i} == count_i;

  // tile covers [c, c+1) x [r, r+1) in 1/256 units
  assign lo_x = CMP_W'(signed'({ent_q.col, 8'h00}));
  assign hi_x = lo_x + CMP_W'(256);
  assign lo_y = CMP_W'(signed'({ent_q.row, 8'h00}));
  assign hi_y = lo_y + CMP_W'(256);
  assign bx0  = CMP_W'(cmd_i.bx);
  assign bx1  = bx0 + signed'(CMP_W'(cmd_i.bw));
  assign by0  = CMP_W'(cmd_i.by);
  assign by1  = by0 + signed'(CMP_W'(cmd_i.bh));

  assign match_d = valid && (ent_q.col == cmd_i.col) && (ent_q.row == cmd_i.row);
  assign hit_d   = valid && ent_q.solid && (bx0 < hi_x) && (bx1 > lo_x) &&
                   (by0 < hi_y) && (by1 > lo_y);

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    hit_q   <= hit_d;
    if (cmd_i.append && at_end) begin
      ent_q <= '{col: cmd_i.col, row: cmd_i.row, solid: cmd_i.solid};
    end else if (cmd_i.shift && shift_i) begin
      ent_q <= nxt_i;
    end else if (cmd_i.replace && first_i) begin
      ent_q.solid <= cmd_i.solid;
    end
  end

  assign ent_o   = ent_q;
  assign match_o = match_q;
  assign hit_o   = hit_q;

endmodule
